// ----- rtl/dsu_pkg.sv -----
// ---------------------------------------------------------------------------
// dsu_pkg
// Shared types, constants and tables of the dynamic synapse update unit.
// ---------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

    // Table size and field widths.
    localparam int NUM_EDGES      = 1024;
    localparam int ADDR_W         = $clog2(NUM_EDGES);
    localparam int EDGE_IDX_W     = 10;
    localparam int STEP_W         = 48;
    localparam int EXP_TABLE_BITS = 8;
    localparam int EXP_POINTS     = (1 << EXP_TABLE_BITS) + 1;
    localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;
    localparam int EXP_SHIFT      = 20 - EXP_TABLE_BITS;

    // Stream payload widths.
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 80;

    // Configuration register indexes.
    localparam logic CFG_STEP_SECONDS = 1'b0;
    localparam logic CFG_DEFAULT_USE  = 1'b1;
    localparam logic [31:0] STEP_SECONDS_RST = 32'd429497;
    localparam logic [15:0] DEFAULT_USE_RST  = 16'd26214;

    typedef enum logic [1:0] {
        FN_CREATE  = 2'd0,
        FN_RESET   = 2'd1,
        FN_SPIKE   = 2'd2,
        FN_INVALID = 2'd3
    } t_func;

    // Per-kind constants: U in Q0.16, 1/D and 1/F in Q6.16.
    typedef logic [15:0] t_use_tab [4];
    typedef logic [21:0] t_inv_tab [4];
    localparam t_use_tab KIND_USE   = '{16'd20972, 16'd16384, 16'd3277, 16'd32768};
    localparam t_inv_tab KIND_INV_D = '{22'd455111, 22'd93623, 22'd524288, 22'd59578};
    localparam t_inv_tab KIND_INV_F = '{22'd1092267, 22'd3276800, 22'd54613, 22'd1310720};

    // One stored synapse.
    typedef struct packed {
        logic [15:0]       rsrc;
        logic [15:0]       usev;
        logic [STEP_W-1:0] last_step;
        logic              spiked;
        logic [1:0]        kind;
        logic [31:0]       weight;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // exp(-x) sample points over [0,16], Q1.16, computed at elaboration.
    typedef logic [16:0] t_exp_tab [EXP_POINTS];

    function automatic t_exp_tab build_exp_tab();
        logic [63:0] h;
        logic [63:0] term;
        logic [63:0] q;
        logic [63:0] t;
        longint      sum;
        t_exp_tab    tab;
        h    = 64'd1 << (35 - EXP_TABLE_BITS);
        term = 64'd1 << 31;
        sum  = longint'(64'd1 << 31);
        t    = 64'd1 << 31;
        for (int n = 1; n <= 24; n++) begin
            term = ((term * h) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        q = (sum > 0) ? 64'(sum) : 64'd0;
        for (int k = 0; k < EXP_POINTS; k++) begin
            tab[k] = 17'((t + (64'd1 << 14)) >> 15);
            t      = (t * q) >> 31;
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

    // Multiplier operand selects.
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_HI_SS,
        MUL_LO_SS,
        MUL_ISI_D,
        MUL_ISI_F,
        MUL_EXP_R,
        MUL_EXP_U,
        MUL_R_U,
        MUL_U_BU,
        MUL_B_ER,
        MUL_T1_EU,
        MUL_UR,
        MUL_W_UR
    } t_mul_sel;

    // Product consumers.
    typedef enum logic [3:0] {
        TK_NONE,
        TK_PHI,
        TK_ISI,
        TK_XR,
        TK_XU,
        TK_ER,
        TK_EU,
        TK_B,
        TK_T1,
        TK_RN,
        TK_UN,
        TK_UR,
        TK_PSR
    } t_take_sel;

    // Controller states.
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF,
        ST_HI,
        ST_LO,
        ST_ISI,
        ST_XD,
        ST_XF,
        ST_ER,
        ST_EU,
        ST_RU,
        ST_UBU,
        ST_BER,
        ST_TEU,
        ST_UNT,
        ST_URM,
        ST_URT,
        ST_WUR,
        ST_PSR,
        ST_FINISH
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic      capture;
        logic      load;
        logic      diff;
        t_mul_sel  mul;
        t_take_sel take;
        logic      out_load;
        logic      mem_we;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic  op_ok;
        t_func func;
        logic  spiked;
        logic  out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ----- rtl/dsu_ram.sv -----
// ---------------------------------------------------------------------------
// dsu_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module dsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/dsu_ctrl.sv -----
// ---------------------------------------------------------------------------
// dsu_ctrl
// Sequencer that walks one item through the shared multiplier schedule.
// ---------------------------------------------------------------------------
`default_nettype none

module dsu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire dsu_pkg::t_stat i_stat,
    output logic               o_in_ready,
    output dsu_pkg::t_cmd      o_cmd
);
    import dsu_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.mul  = MUL_NONE;
        o_cmd.take = TK_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                if (!i_stat.op_ok || i_stat.func != FN_SPIKE) begin
                    n_state = ST_FINISH;
                end else if (i_stat.spiked) begin
                    n_state = ST_DIFF;
                end else begin
                    n_state = ST_URM;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_HI;
            end
            ST_HI: begin
                o_cmd.mul = MUL_HI_SS;
                n_state   = ST_LO;
            end
            ST_LO: begin
                o_cmd.mul  = MUL_LO_SS;
                o_cmd.take = TK_PHI;
                n_state    = ST_ISI;
            end
            ST_ISI: begin
                o_cmd.take = TK_ISI;
                n_state    = ST_XD;
            end
            ST_XD: begin
                o_cmd.mul = MUL_ISI_D;
                n_state   = ST_XF;
            end
            ST_XF: begin
                o_cmd.mul  = MUL_ISI_F;
                o_cmd.take = TK_XR;
                n_state    = ST_ER;
            end
            ST_ER: begin
                o_cmd.mul  = MUL_EXP_R;
                o_cmd.take = TK_XU;
                n_state    = ST_EU;
            end
            ST_EU: begin
                o_cmd.mul  = MUL_EXP_U;
                o_cmd.take = TK_ER;
                n_state    = ST_RU;
            end
            ST_RU: begin
                o_cmd.mul  = MUL_R_U;
                o_cmd.take = TK_EU;
                n_state    = ST_UBU;
            end
            ST_UBU: begin
                o_cmd.mul  = MUL_U_BU;
                o_cmd.take = TK_B;
                n_state    = ST_BER;
            end
            ST_BER: begin
                o_cmd.mul  = MUL_B_ER;
                o_cmd.take = TK_T1;
                n_state    = ST_TEU;
            end
            ST_TEU: begin
                o_cmd.mul  = MUL_T1_EU;
                o_cmd.take = TK_RN;
                n_state    = ST_UNT;
            end
            ST_UNT: begin
                o_cmd.take = TK_UN;
                n_state    = ST_URM;
            end
            ST_URM: begin
                o_cmd.mul = MUL_UR;
                n_state   = ST_URT;
            end
            ST_URT: begin
                o_cmd.take = TK_UR;
                n_state    = ST_WUR;
            end
            ST_WUR: begin
                o_cmd.mul = MUL_W_UR;
                n_state   = ST_PSR;
            end
            ST_PSR: begin
                o_cmd.take = TK_PSR;
                n_state    = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold here while the previous result is still unread.
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.mem_we   = i_stat.op_ok;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/dsu_datapath.sv -----
// ---------------------------------------------------------------------------
// dsu_datapath
// Synapse table, configuration registers, shared multiplier and result stage.
// ---------------------------------------------------------------------------
`default_nettype none

module dsu_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [31:0]                     i_cfg_wdata,
    input  wire logic [dsu_pkg::IN_DATA_W-1:0]   i_in_data,
    input  wire logic [1:0]                      i_in_user,
    input  wire logic                            i_out_ready,
    input  wire dsu_pkg::t_cmd                   i_cmd,
    output dsu_pkg::t_stat                       o_stat,
    output logic                                 o_out_valid,
    output logic      [dsu_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic                                 o_out_user
);
    import dsu_pkg::*;

    // Configuration.
    logic [31:0] r_step_seconds;
    logic [15:0] r_default_use;

    // Captured item.
    t_func                 r_func;
    logic                  r_op_ok;
    logic [EDGE_IDX_W-1:0] r_idx;
    logic [1:0]            r_kind_in;
    logic [31:0]           r_w_in;
    logic [STEP_W-1:0]     r_now;

    // Working registers.
    t_entry            r_ent;
    t_entry            ram_rdata;
    t_entry            ram_wdata;
    logic [STEP_W-1:0] r_diff;
    logic [63:0]       r_prod;
    logic [31:0]       r_phi;
    logic              r_phi_sat;
    logic [31:0]       r_isi;
    logic [19:0]       r_xr;
    logic              r_xr_sat;
    logic [19:0]       r_xu;
    logic              r_xu_sat;
    logic [16:0]       r_base_r;
    logic [16:0]       r_base_u;
    logic [16:0]       r_er;
    logic [16:0]       r_eu;
    logic [16:0]       r_b;
    logic [15:0]       r_t1;
    logic [15:0]       r_rn;
    logic [15:0]       r_un;
    logic [15:0]       r_ur;
    logic [31:0]       r_psr;

    // Output register.
    logic                  r_out_valid;
    logic [EDGE_IDX_W-1:0] r_out_idx;
    logic [31:0]           r_out_psr;
    logic [15:0]           r_out_r;
    logic [15:0]           r_out_u;
    logic                  r_out_status;

    logic [EDGE_IDX_W-1:0] in_idx;
    t_func                 in_func;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [19:0]           exp_x;
    logic [EXP_IDX_W-1:0]  exp_i;
    logic [16:0]           exp_base;
    logic [16:0]           exp_next;
    logic [16:0]           exp_d;
    logic [15:0]           kind_u;
    logic [16:0]           one_minus_bu;
    logic [31:0]           w_mag;
    logic                  w_neg;
    logic [32:0]           isi_sum;
    logic [16:0]           rn_val;
    logic [16:0]           un_val;
    logic [31:0]           mag_s;

    assign in_idx  = i_in_data[EDGE_IDX_W-1:0];
    assign in_func = t_func'(i_in_user);

    // Synapse table; read is launched with the incoming beat.
    dsu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_EDGES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (r_idx[ADDR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (in_idx[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_seconds <= STEP_SECONDS_RST;
            r_default_use  <= DEFAULT_USE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEP_SECONDS: r_step_seconds <= i_cfg_wdata;
                CFG_DEFAULT_USE:  r_default_use  <= i_cfg_wdata[15:0];
                default:          r_step_seconds <= r_step_seconds;
            endcase
        end
    end

    // Per-kind use and weight magnitude.
    assign kind_u       = KIND_USE[r_ent.kind];
    assign one_minus_bu = 17'h10000 - {1'b0, kind_u};
    assign w_neg        = r_ent.weight[31];
    assign w_mag        = w_neg ? (~r_ent.weight + 32'd1) : r_ent.weight;

    // Exponential table lookup for the operand being multiplied.
    assign exp_x    = (i_cmd.mul == MUL_EXP_U) ? r_xu : r_xr;
    assign exp_i    = {1'b0, exp_x[19:EXP_SHIFT]};
    assign exp_base = EXP_TAB[exp_i];
    assign exp_next = EXP_TAB[exp_i + 1'b1];
    assign exp_d    = (exp_base > exp_next) ? (exp_base - exp_next) : 17'd0;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul)
            MUL_HI_SS: begin
                mul_a = r_diff[47:16];
                mul_b = r_step_seconds;
            end
            MUL_LO_SS: begin
                mul_a = {16'd0, r_diff[15:0]};
                mul_b = r_step_seconds;
            end
            MUL_ISI_D: begin
                mul_a = r_isi;
                mul_b = {10'd0, KIND_INV_D[r_ent.kind]};
            end
            MUL_ISI_F: begin
                mul_a = r_isi;
                mul_b = {10'd0, KIND_INV_F[r_ent.kind]};
            end
            MUL_EXP_R, MUL_EXP_U: begin
                mul_a = {15'd0, exp_d};
                mul_b = {{(32 - EXP_SHIFT){1'b0}}, exp_x[EXP_SHIFT-1:0]};
            end
            MUL_R_U: begin
                mul_a = {16'd0, r_ent.rsrc};
                mul_b = {15'd0, 17'h10000 - {1'b0, r_ent.usev}};
            end
            MUL_U_BU: begin
                mul_a = {16'd0, r_ent.usev};
                mul_b = {15'd0, one_minus_bu};
            end
            MUL_B_ER: begin
                mul_a = {15'd0, r_b};
                mul_b = {15'd0, r_er};
            end
            MUL_T1_EU: begin
                mul_a = {16'd0, r_t1};
                mul_b = {15'd0, r_eu};
            end
            MUL_UR: begin
                mul_a = {16'd0, r_un};
                mul_b = {16'd0, r_rn};
            end
            MUL_W_UR: begin
                mul_a = w_mag;
                mul_b = {16'd0, r_ur};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);
    end

    // Post-processing of the previous product.
    assign isi_sum = {1'b0, r_phi} + {1'b0, r_prod[47:16]};
    assign rn_val  = 17'h10000 - r_prod[32:16];
    assign un_val  = {1'b0, kind_u} + {1'b0, r_prod[31:16]};
    assign mag_s   = r_prod[47:16];

    // Item capture and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= in_func;
            r_op_ok   <= (in_func != FN_INVALID) &&
                         ({{(32 - EDGE_IDX_W){1'b0}}, in_idx} < 32'(NUM_EDGES));
            r_idx     <= in_idx;
            r_kind_in <= i_in_data[11:10];
            r_w_in    <= i_in_data[43:12];
            r_now     <= i_in_data[91:44];
        end
        if (i_cmd.load) begin
            r_ent <= ram_rdata;
            r_psr <= '0;
            if (r_func == FN_SPIKE) begin
                r_rn <= ram_rdata.rsrc;
                r_un <= ram_rdata.usev;
            end else begin
                r_rn <= 16'hFFFF;
                r_un <= r_default_use;
            end
        end
        if (i_cmd.diff) begin
            r_diff <= r_now - r_ent.last_step;
        end
        if (i_cmd.mul == MUL_EXP_R) begin
            r_base_r <= exp_base;
        end
        if (i_cmd.mul == MUL_EXP_U) begin
            r_base_u <= exp_base;
        end
        case (i_cmd.take)
            TK_PHI: begin
                r_phi     <= r_prod[31:0];
                r_phi_sat <= |r_prod[63:32];
            end
            TK_ISI: begin
                r_isi <= (r_phi_sat || isi_sum[32]) ? 32'hFFFF_FFFF : isi_sum[31:0];
            end
            TK_XR: begin
                r_xr     <= r_prod[35:16];
                r_xr_sat <= |r_prod[63:36];
            end
            TK_XU: begin
                r_xu     <= r_prod[35:16];
                r_xu_sat <= |r_prod[63:36];
            end
            TK_ER: begin
                r_er <= r_xr_sat ? 17'd0 : (r_base_r - r_prod[EXP_SHIFT+16:EXP_SHIFT]);
            end
            TK_EU: begin
                r_eu <= r_xu_sat ? 17'd0 : (r_base_u - r_prod[EXP_SHIFT+16:EXP_SHIFT]);
            end
            TK_B: begin
                r_b <= 17'h10000 - {1'b0, r_prod[31:16]};
            end
            TK_T1: begin
                r_t1 <= r_prod[31:16];
            end
            TK_RN: begin
                r_rn <= rn_val[16] ? 16'hFFFF : rn_val[15:0];
            end
            TK_UN: begin
                r_un <= un_val[16] ? 16'hFFFF : un_val[15:0];
            end
            TK_UR: begin
                r_ur <= r_prod[31:16];
            end
            TK_PSR: begin
                // Saturate the magnitude, then apply the weight's sign.
                if (w_neg) begin
                    r_psr <= (mag_s > 32'h8000_0000) ? 32'h8000_0000 : (~mag_s + 32'd1);
                end else begin
                    r_psr <= (mag_s > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag_s;
                end
            end
            default: begin
                r_ur <= r_ur;
            end
        endcase
    end

    // Entry written back at the end of the item.
    always_comb begin
        ram_wdata      = r_ent;
        ram_wdata.rsrc = r_rn;
        ram_wdata.usev = r_un;
        if (r_func == FN_SPIKE) begin
            ram_wdata.last_step = r_now;
            ram_wdata.spiked    = 1'b1;
        end else begin
            ram_wdata.spiked = 1'b0;
        end
        if (r_func == FN_CREATE) begin
            ram_wdata.kind   = r_kind_in;
            ram_wdata.weight = r_w_in;
        end
    end

    // Result register; it frees itself when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_idx    <= r_idx;
            r_out_status <= !r_op_ok;
            r_out_psr    <= r_op_ok ? r_psr : 32'd0;
            r_out_r      <= r_op_ok ? r_rn : 16'd0;
            r_out_u      <= r_op_ok ? r_un : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {6'd0, r_out_u, r_out_r, r_out_psr, r_out_idx};
    assign o_out_user  = r_out_status;

    // Status to the controller.
    assign o_stat.op_ok    = r_op_ok;
    assign o_stat.func     = r_func;
    assign o_stat.spiked   = ram_rdata.spiked;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// ----- rtl/dynamic_synapse_update_unit.sv -----
// ---------------------------------------------------------------------------
// dynamic_synapse_update_unit
// Table of short-term plasticity synapses with create, reset and spike items.
// ---------------------------------------------------------------------------
//   Port group     Dir  Beat contents
//   s_axis_*       in   tdata: edge_index, edge_kind, weight_scaled, step_now;
//                       tuser: func
//   m_axis_*       out  tdata: edge_echo, psr_increment, resource_out, use_out;
//                       tuser: status
//   i_cfg_*        in   register write: step_seconds (0), default_use (1)
//
// A spike on a synapse that has spiked before runs the whole product chain,
// a first spike only the use-resource and weight products; create, reset or
// an ignored beat go straight to the last step. The chain of dependent
// products runs through the one shared 32x32 multiplier. One item is in work
// at a time; a new beat is taken once the result sits in the output register.
// If that register is still full, the item waits in its last step. Reset is
// synchronous; table contents are undefined until written.
// ---------------------------------------------------------------------------
`default_nettype none

module dynamic_synapse_update_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port.
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_index,
    input  wire logic [31:0]                     i_cfg_wdata,
    // Input stream.
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [9:0] edge_index, [11:10] edge_kind, [43:12] weight_scaled,
    // [91:44] step_now, [95:92] zero
    input  wire logic [dsu_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] func
    input  wire logic [1:0]                      s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [9:0] edge_echo, [41:10] psr_increment, [57:42] resource_out,
    // [73:58] use_out, [79:74] zero
    output logic      [dsu_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] status
    output logic                                 m_axis_tuser
);
    import dsu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    dsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Table, arithmetic and result register.
    dsu_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    // After an accepted beat the input is not ready in the cycle that follows.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // A result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("result loaded over an unread beat");

    // The table is written only while no new beat can be taken.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_we |-> !s_axis_tready && cmd.out_load)
        else $error("table written outside the closing step");

    // Each completed item shows a valid result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |=> m_axis_tvalid)
        else $error("result missing after completion");

endmodule

`default_nettype wire
